@@ src/moqs_pkg.sv @@
package moqs_pkg;

    // Item kinds carried on s_tuser
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_POP     = 1'b1;

    // Message check limits
    localparam logic [7:0] PORT_LOW  = 8'd1;
    localparam logic [7:0] PORT_HIGH = 8'd6;
    localparam logic [7:0] TYPE_LOW  = 8'h80;
    localparam logic [7:0] TYPE_HIGH = 8'hEF;

    // Stored message layout, lowest bit first: port, type, channel, data1, data2
    localparam int ENTRY_W = 36;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    // Stage-one word, waiting for the popped entry to come out of the store
    typedef struct packed {
        logic        accepted;
        logic        popped;
        logic        drop_full;
        logic [7:0]  depth;
        logic [7:0]  high_water;
        logic [31:0] queued;
    } stage_t;

endpackage

@@ src/moqs_ram.sv @@
module moqs_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/midi_output_queue_with_stats_core.sv @@
// MIDI output queue with statistics.
// Input channel s_*: one word per command. s_tuser selects enqueue (message
// fields in s_tdata are stored) or pop (oldest message is removed and checked).
// Output channel m_*: exactly one result word per input word, in order. It
// carries the popped message (channel shown 1..16), accept and send flags, the
// depth after the command, the depth high-water mark and three saturating
// 32-bit counters (queued, sent, dropped).
// The queue holds at most QUEUE_SIZE-1 messages; an enqueue into a full queue
// is dropped and counted, a pop of an empty queue changes nothing.
// Each accepted word passes stage one (pointer update and store access), then
// stage two (registered store read, port/type check and counter update), which
// loads the output register. Throughput is one word per cycle while m_tready
// keeps the output register free.
// Stall: stage one and the output register together absorb two words, so the
// block keeps taking a word while a result waits; s_tready drops only when
// both are full and m_tready is low.
// Reset clears pointers, depth, high-water mark, counters and valid flags;
// the store itself is not cleared, since only written entries are read.
module midi_output_queue_with_stats_core #(
    parameter int QUEUE_SIZE = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [7:0] msg_port, [15:8] msg_type, [19:16] msg_channel, [27:20] msg_data1,
    // [35:28] msg_data2, [39:36] zero
    input  logic [39:0]  s_tdata,
    // [0] opcode
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [7:0] out_port, [15:8] out_type, [20:16] out_channel, [28:21] out_data1,
    // [36:29] out_data2, [44:37] queue_depth, [52:45] high_water,
    // [84:53] queued_count, [116:85] sent_count, [148:117] dropped_count,
    // [151:149] zero
    output logic [151:0] m_tdata,
    // [0] accepted, [1] send_valid
    output logic [1:0]   m_tuser
);

    import moqs_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_SIZE);
    localparam int EXT_W = PTR_W + 8;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_SIZE - 1);
    localparam logic [PTR_W-1:0] DEPTH_FULL = PTR_W'(QUEUE_SIZE - 1);
    localparam logic [EXT_W-1:0] SAT8_MAX = EXT_W'(255);

    // Handshake
    logic s_accept;
    logic s1_advance;
    logic out_free;

    logic             s1_valid_reg;
    stage_t           s1_reg;
    stage_t           s1_next;

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W-1:0] depth_reg;
    logic [PTR_W-1:0] depth_next;
    logic [PTR_W-1:0] peak_reg;
    logic [PTR_W-1:0] peak_next;
    logic [31:0]      queued_reg;
    logic [31:0]      queued_next;
    logic [31:0]      sent_reg;
    logic [31:0]      sent_next;
    logic [31:0]      dropped_reg;
    logic [31:0]      dropped_next;

    logic               is_enqueue;
    logic               is_full;
    logic               is_empty;
    logic               do_write;
    logic               do_read;
    logic [ENTRY_W-1:0] wr_entry;
    logic [ENTRY_W-1:0] rd_entry;
    logic [EXT_W-1:0]   depth_ext;
    logic [EXT_W-1:0]   peak_ext;

    logic         m_valid_reg;
    logic [151:0] m_data_reg;
    logic [151:0] m_data_next;
    logic [1:0]   m_user_reg;
    logic [1:0]   m_user_next;

    logic [7:0] pop_port;
    logic [7:0] pop_type;
    logic [3:0] pop_chan;
    logic [7:0] pop_d1;
    logic [7:0] pop_d2;
    logic       pop_ok;
    logic       send_ok;
    logic       drop_now;
    logic [7:0] res_port;
    logic [7:0] res_type;
    logic [4:0] res_chan;
    logic [7:0] res_d1;
    logic [7:0] res_d2;

    assign out_free   = !m_valid_reg || m_tready;
    assign s1_advance = s1_valid_reg && out_free;
    assign s_tready   = !s1_valid_reg || out_free;
    assign s_accept   = s_tvalid && s_tready;

    // Stage one: pointers, depth, high-water mark, queued count
    assign is_enqueue = (s_tuser[0] == OP_ENQUEUE);
    assign is_full    = (depth_reg == DEPTH_FULL);
    assign is_empty   = (depth_reg == '0);
    assign do_write   = s_accept && is_enqueue && !is_full;
    assign do_read    = s_accept && !is_enqueue && !is_empty;
    assign wr_entry   = s_tdata[ENTRY_W-1:0];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        depth_next  = depth_reg;
        peak_next   = peak_reg;
        queued_next = queued_reg;
        if (do_write)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            depth_next  = depth_reg + 1'b1;
            if (depth_next > peak_reg)
            begin
                peak_next = depth_next;
            end
            if (queued_reg != COUNT_MAX)
            begin
                queued_next = queued_reg + 32'd1;
            end
        end
        else if (do_read)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            depth_next  = depth_reg - 1'b1;
        end
    end

    // Clamp depth and mark to eight bits
    assign depth_ext = {8'd0, depth_next};
    assign peak_ext  = {8'd0, peak_next};

    always_comb
    begin
        s1_next.accepted   = do_write || do_read;
        s1_next.popped     = do_read;
        s1_next.drop_full  = is_enqueue && is_full;
        s1_next.depth      = (depth_ext > SAT8_MAX) ? 8'hFF : depth_ext[7:0];
        s1_next.high_water = (peak_ext > SAT8_MAX) ? 8'hFF : peak_ext[7:0];
        s1_next.queued     = queued_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            depth_reg    <= '0;
            peak_reg     <= '0;
            queued_reg   <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            depth_reg  <= depth_next;
            peak_reg   <= peak_next;
            queued_reg <= queued_next;
            if (s_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the stage-one word while it waits
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_reg <= s1_next;
        end
    end

    // Message store
    moqs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_SIZE)
    ) u_store (
        .clk     (clk),
        .wr_en   (do_write),
        .wr_addr (wr_ptr_reg),
        .wr_data (wr_entry),
        .rd_en   (do_read),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_entry)
    );

    // Stage two: check the popped message, update sent and dropped counts
    assign pop_port = rd_entry[7:0];
    assign pop_type = rd_entry[15:8];
    assign pop_chan = rd_entry[19:16];
    assign pop_d1   = rd_entry[27:20];
    assign pop_d2   = rd_entry[35:28];
    assign pop_ok   = (pop_port >= PORT_LOW) && (pop_port <= PORT_HIGH)
                   && (pop_type >= TYPE_LOW) && (pop_type <= TYPE_HIGH);
    assign send_ok  = s1_reg.popped && pop_ok;
    assign drop_now = s1_reg.drop_full || (s1_reg.popped && !pop_ok);

    assign res_port = s1_reg.popped ? pop_port : 8'd0;
    assign res_type = s1_reg.popped ? pop_type : 8'd0;
    assign res_chan = s1_reg.popped ? ({1'b0, pop_chan} + 5'd1) : 5'd0;
    assign res_d1   = s1_reg.popped ? pop_d1 : 8'd0;
    assign res_d2   = s1_reg.popped ? pop_d2 : 8'd0;

    always_comb
    begin
        sent_next    = sent_reg;
        dropped_next = dropped_reg;
        if (s1_advance)
        begin
            if (send_ok && (sent_reg != COUNT_MAX))
            begin
                sent_next = sent_reg + 32'd1;
            end
            if (drop_now && (dropped_reg != COUNT_MAX))
            begin
                dropped_next = dropped_reg + 32'd1;
            end
        end
    end

    assign m_data_next = {3'd0, dropped_next, sent_next, s1_reg.queued,
                          s1_reg.high_water, s1_reg.depth,
                          res_d2, res_d1, res_chan, res_type, res_port};
    assign m_user_next = {send_ok, s1_reg.accepted};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg    <= '0;
            dropped_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            sent_reg    <= sent_next;
            dropped_reg <= dropped_next;
            if (s1_advance)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Load the result word
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
